// ===== rtl/core/vbr_pkg.sv =====
package vbr_pkg;

   typedef enum logic [1:0] {
      REQ_VIDEO_WR = 2'd0,
      REQ_RENDER   = 2'd1,
      REQ_FONT_WR  = 2'd2,
      REQ_PAL_WR   = 2'd3
   } req_kind_type;

   localparam logic [1:0]  MODE_TEXT        = 2'd0;
   localparam logic [1:0]  MODE_GFX         = 2'd2;
   localparam logic [15:0] TEXT_LIMIT       = 16'd4000;
   localparam logic [3:0]  CURSOR_FIRST_ROW = 4'd14;
   localparam logic [7:0]  DIV5_MUL         = 8'd205;
   localparam int          FONT_BYTES       = 4096;
   localparam int          PAL_BYTES        = 512;

   localparam logic [2:0] REG_VIDEO_MODE   = 3'd0;
   localparam logic [2:0] REG_SUPPRESS     = 3'd1;
   localparam logic [2:0] REG_CURSOR_COL   = 3'd2;
   localparam logic [2:0] REG_CURSOR_ROW   = 3'd3;
   localparam logic [2:0] REG_BLINK_PHASE  = 3'd4;

   typedef struct packed {
      logic [1:0] video_mode;
      logic       render_suppress;
      logic [6:0] cursor_column;
      logic [4:0] cursor_row;
      logic       cursor_blink_phase;
   } cfg_type;

   // classified request as it waits between front and back
   typedef struct packed {
      req_kind_type kind;
      logic [15:0]  address;
      logic [7:0]   data;
      logic         text;
      logic         gfx;
      logic [7:0]   quot;
   } entry_type;

   typedef struct packed {
      logic [10:0] screen_x;
      logic [9:0]  screen_y;
      logic [7:0]  pixel_mask;
      logic [3:0]  pixel_count;
      logic [2:0]  pixel_size;
      logic [23:0] fg_color;
      logic [23:0] bg_color;
      logic        last;
   } row_type;

   function automatic logic [23:0] rgb(input logic [7:0] gb, input logic [7:0] r);
      return {r[3:0], 4'h0, gb[7:4], 4'h0, gb[3:0], 4'h0};
   endfunction

endpackage

// ===== rtl/core/video_byte_renderer.sv =====
// flow: an accepted request waits in a two-entry front queue until the back end is idle and
// pops it; the back end handles one request at a time. A text render does two video reads,
// four palette reads, then one font read per row; a graphics render reads one video byte and
// two palette bytes, then emits a single pixel; a store write takes effect on the pop.
// reset: synchronous; after it the stores are zeroed by a sweep of VIDEO_MEMORY_BYTES
// addresses during which req_tready stays low (register writes are taken).
module video_byte_renderer #(
   parameter int VIDEO_MEMORY_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // address[15:0], data[23:16]
   input  logic [1:0]  req_tuser,   // req_type[1:0]

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // screen_x[10:0], screen_y[20:11], pixel_mask[28:21], pixel_count[32:29],
   // pixel_size[35:33], fg_color[59:36], bg_color[83:60], zero fill[87:84]
   output logic [87:0] rsp_tdata,
   output logic        rsp_tlast,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   vbr_pkg::cfg_type   cfg_ff;
   logic [2:0]         reg_idx;
   logic               csr_wr;
   logic               q_valid, q_pop, clearing;
   vbr_pkg::entry_type q_entry;
   vbr_pkg::row_type   rsp_row;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr) begin
         case (reg_idx)
            vbr_pkg::REG_VIDEO_MODE:  cfg_ff.video_mode         <= csr_pwdata[1:0];
            vbr_pkg::REG_SUPPRESS:    cfg_ff.render_suppress    <= csr_pwdata[0];
            vbr_pkg::REG_CURSOR_COL:  cfg_ff.cursor_column      <= csr_pwdata[6:0];
            vbr_pkg::REG_CURSOR_ROW:  cfg_ff.cursor_row         <= csr_pwdata[4:0];
            vbr_pkg::REG_BLINK_PHASE: cfg_ff.cursor_blink_phase <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         vbr_pkg::REG_VIDEO_MODE:  csr_prdata = {30'd0, cfg_ff.video_mode};
         vbr_pkg::REG_SUPPRESS:    csr_prdata = {31'd0, cfg_ff.render_suppress};
         vbr_pkg::REG_CURSOR_COL:  csr_prdata = {25'd0, cfg_ff.cursor_column};
         vbr_pkg::REG_CURSOR_ROW:  csr_prdata = {27'd0, cfg_ff.cursor_row};
         vbr_pkg::REG_BLINK_PHASE: csr_prdata = {31'd0, cfg_ff.cursor_blink_phase};
         default:                  csr_prdata = 32'd0;
      endcase
   end

   vbr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .hold       (clearing),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_kind    (req_tuser),
      .in_address (req_tdata[15:0]),
      .in_data    (req_tdata[23:16]),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop)
   );

   vbr_back #(.VIDEO_MEMORY_BYTES(VIDEO_MEMORY_BYTES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop),
      .clearing  (clearing),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_row   (rsp_row)
   );

   assign rsp_tdata = {4'h0, rsp_row.bg_color, rsp_row.fg_color, rsp_row.pixel_size,
                       rsp_row.pixel_count, rsp_row.pixel_mask, rsp_row.screen_y,
                       rsp_row.screen_x};
   assign rsp_tlast = rsp_row.last;

`ifndef SYNTHESIS
   a_no_req_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_tready)
      else $error("request taken during store clearing");

   a_no_rsp_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !rsp_tvalid)
      else $error("result shown during store clearing");

   a_row_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_row.pixel_size == 3'd2 && rsp_row.pixel_count == 4'd8)
                  || (rsp_row.pixel_size == 3'd4 && rsp_row.pixel_count == 4'd1
                      && rsp_row.pixel_mask == 8'h80 && rsp_row.bg_color == 24'h0
                      && rsp_row.last))
      else $error("result row mixes text and graphics fields");
`endif

endmodule

// ===== rtl/core/vbr_ram.sv =====
module vbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/vbr_front.sv =====
module vbr_front (
   input  logic                clock,
   input  logic                reset,
   input  vbr_pkg::cfg_type    cfg,
   input  logic                hold,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [1:0]          in_kind,
   input  logic [15:0]         in_address,
   input  logic [7:0]          in_data,
   output logic                q_valid,
   output vbr_pkg::entry_type  q_entry,
   input  logic                q_pop
);

   vbr_pkg::entry_type q_ff [2];
   logic [1:0]         cnt_ff, cnt_in;
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;

   vbr_pkg::entry_type ent;
   logic               renders;
   logic [9:0]         div_in;
   logic [17:0]        div_prod;
   logic               push, pop;

   always_comb begin
      ent.kind    = vbr_pkg::req_kind_type'(in_kind);
      ent.address = in_address;
      ent.data    = in_data;
      renders     = (ent.kind == vbr_pkg::REQ_VIDEO_WR || ent.kind == vbr_pkg::REQ_RENDER)
                    && !cfg.render_suppress;
      ent.text    = renders && cfg.video_mode == vbr_pkg::MODE_TEXT
                    && in_address < vbr_pkg::TEXT_LIMIT;
      ent.gfx     = renders && cfg.video_mode == vbr_pkg::MODE_GFX;
      // text row = cell/80 = (a>>5)/5, graphics row = a/320 = (a>>6)/5
      div_in      = ent.text ? in_address[14:5] : in_address[15:6];
      div_prod    = 18'(div_in) * 18'(vbr_pkg::DIV5_MUL);
      ent.quot    = div_prod[17:10];
   end

   assign in_ready = !hold && cnt_ff != 2'd2;
   assign push     = in_valid && in_ready;
   assign pop      = q_pop && q_valid;
   assign q_valid  = cnt_ff != 2'd0;
   assign q_entry  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= ent;
      end
   end

endmodule

// ===== rtl/core/vbr_back.sv =====
module vbr_back #(
   parameter int VIDEO_MEMORY_BYTES = 65536
) (
   input  logic                clock,
   input  logic                reset,
   input  vbr_pkg::cfg_type    cfg,
   input  logic                q_valid,
   input  vbr_pkg::entry_type  q_entry,
   output logic                q_pop,
   output logic                clearing,
   output logic                out_valid,
   input  logic                out_ready,
   output vbr_pkg::row_type    out_row
);

   localparam int VAW = $clog2(VIDEO_MEMORY_BYTES);
   localparam int FAW = $clog2(vbr_pkg::FONT_BYTES);
   localparam int PAW = $clog2(vbr_pkg::PAL_BYTES);

   typedef enum logic [13:0] {
      ST_CLEAR  = 14'b00000000000001,
      ST_IDLE   = 14'b00000000000010,
      ST_TCODE  = 14'b00000000000100,
      ST_TATTR  = 14'b00000000001000,
      ST_TPAL0  = 14'b00000000010000,
      ST_TPAL1  = 14'b00000000100000,
      ST_TPAL2  = 14'b00000001000000,
      ST_TPAL3  = 14'b00000010000000,
      ST_TFONT0 = 14'b00000100000000,
      ST_TROW   = 14'b00001000000000,
      ST_GREM   = 14'b00010000000000,
      ST_GPAL0  = 14'b00100000000000,
      ST_GPAL1  = 14'b01000000000000,
      ST_GEMIT  = 14'b10000000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [VAW-1:0]     clr_ff, clr_in;
   vbr_pkg::entry_type cur_ff;
   logic [6:0]         col_ff;
   logic [8:0]         gx_ff;
   logic [7:0]         code_ff, attr_ff, pix_ff;
   logic [7:0]         fg_gb_ff, fg_r_ff, bg_gb_ff, bg_r_ff;
   logic [3:0]         idx_ff, idx_in;
   logic               vok_ff;
   logic               out_valid_ff, out_valid_in;
   vbr_pkg::row_type   out_row_ff;

   logic               vram_we, font_we, pal_we;
   logic [VAW-1:0]     vram_wa;
   logic [FAW-1:0]     font_wa;
   logic [PAW-1:0]     pal_wa;
   logic [7:0]         wdata;
   logic [15:0]        vram_ra16;
   logic               vram_rok;
   logic [FAW-1:0]     font_ra;
   logic [PAW-1:0]     pal_ra;
   logic [7:0]         vram_rd, font_rd, pal_rd, vbyte;

   logic               pop, load, emit, on_cursor;
   logic [10:0]        cell_no, row80, col_diff;
   logic [15:0]        mul320, gdiff;
   vbr_pkg::row_type   row;

   assign clearing = state_ff == ST_CLEAR;
   assign pop      = state_ff == ST_IDLE && q_valid;
   assign q_pop    = pop;
   assign load     = !out_valid_ff || out_ready;
   assign emit     = load && (state_ff == ST_TROW || state_ff == ST_GEMIT);
   assign vbyte    = vok_ff ? vram_rd : 8'h00;

   // store writes: zero sweep after reset, else the popped request
   always_comb begin
      wdata   = clearing ? 8'h00 : q_entry.data;
      vram_we = clearing || (pop && q_entry.kind == vbr_pkg::REQ_VIDEO_WR
                && {1'b0, q_entry.address} < 17'(VIDEO_MEMORY_BYTES));
      font_we = clearing || (pop && q_entry.kind == vbr_pkg::REQ_FONT_WR
                && q_entry.address[15:FAW] == '0);
      pal_we  = clearing || (pop && q_entry.kind == vbr_pkg::REQ_PAL_WR
                && q_entry.address[15:PAW] == '0);
      vram_wa = clearing ? clr_ff : q_entry.address[VAW-1:0];
      font_wa = clearing ? clr_ff[FAW-1:0] : q_entry.address[FAW-1:0];
      pal_wa  = clearing ? clr_ff[PAW-1:0] : q_entry.address[PAW-1:0];
   end

   always_comb begin
      case (state_ff)
         ST_TCODE: vram_ra16 = {cur_ff.address[15:1], 1'b0};
         ST_TATTR: vram_ra16 = {cur_ff.address[15:1], 1'b1};
         default:  vram_ra16 = cur_ff.address;
      endcase
      vram_rok = {1'b0, vram_ra16} < 17'(VIDEO_MEMORY_BYTES);

      case (state_ff)
         ST_TPAL0: pal_ra = {4'h0, vbyte[3:0], 1'b0};
         ST_TPAL1: pal_ra = {4'h0, attr_ff[3:0], 1'b1};
         ST_TPAL2: pal_ra = {4'h0, attr_ff[7:4], 1'b0};
         ST_TPAL3: pal_ra = {4'h0, attr_ff[7:4], 1'b1};
         ST_GPAL0: pal_ra = {vbyte, 1'b0};
         ST_GPAL1: pal_ra = {pix_ff, 1'b1};
         ST_GEMIT: pal_ra = {pix_ff, 1'b1};
         default:  pal_ra = '0;
      endcase

      // font row reads run one ahead; a stalled row is read again
      idx_in = idx_ff;
      case (state_ff)
         ST_TFONT0: idx_in = 4'd0;
         ST_TROW:   idx_in = load ? idx_ff + 4'd1 : idx_ff;
         default:   idx_in = idx_ff;
      endcase
      font_ra = {code_ff, (state_ff == ST_TROW) ? idx_in : 4'd0};
   end

   always_comb begin
      cell_no  = cur_ff.address[11:1];
      row80    = 11'({cur_ff.quot, 6'b0}) + 11'({cur_ff.quot, 4'b0});
      col_diff = cell_no - row80;
      mul320   = {cur_ff.quot, 8'h00} + {2'b00, cur_ff.quot, 6'b0};
      gdiff    = cur_ff.address - mul320;
   end

   always_comb begin
      on_cursor = col_ff == cfg.cursor_column && {3'b000, cfg.cursor_row} == cur_ff.quot
                  && idx_ff >= vbr_pkg::CURSOR_FIRST_ROW && cfg.cursor_blink_phase;
      if (state_ff == ST_GEMIT) begin
         row.screen_x    = {gx_ff, 2'b00};
         row.screen_y    = {cur_ff.quot, 2'b00};
         row.pixel_mask  = 8'h80;
         row.pixel_count = 4'd1;
         row.pixel_size  = 3'd4;
         row.fg_color    = vbr_pkg::rgb(fg_gb_ff, pal_rd);
         row.bg_color    = 24'h000000;
         row.last        = 1'b1;
      end else begin
         row.screen_x    = {col_ff, 4'h0};
         row.screen_y    = {cur_ff.quot[4:0], 5'b0} + {5'b0, idx_ff, 1'b0};
         row.pixel_mask  = font_rd ^ {8{on_cursor}};
         row.pixel_count = 4'd8;
         row.pixel_size  = 3'd2;
         row.fg_color    = vbr_pkg::rgb(fg_gb_ff, fg_r_ff);
         row.bg_color    = vbr_pkg::rgb(bg_gb_ff, bg_r_ff);
         row.last        = idx_ff == 4'd15;
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + VAW'(1);
            if (clr_ff == VAW'(VIDEO_MEMORY_BYTES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (pop) begin
               if (q_entry.text)     state_in = ST_TCODE;
               else if (q_entry.gfx) state_in = ST_GREM;
            end
         end
         ST_TCODE:  state_in = ST_TATTR;
         ST_TATTR:  state_in = ST_TPAL0;
         ST_TPAL0:  state_in = ST_TPAL1;
         ST_TPAL1:  state_in = ST_TPAL2;
         ST_TPAL2:  state_in = ST_TPAL3;
         ST_TPAL3:  state_in = ST_TFONT0;
         ST_TFONT0: state_in = ST_TROW;
         ST_TROW: begin
            if (load && idx_ff == 4'd15) state_in = ST_IDLE;
         end
         ST_GREM:   state_in = ST_GPAL0;
         ST_GPAL0:  state_in = ST_GPAL1;
         ST_GPAL1:  state_in = ST_GEMIT;
         ST_GEMIT: begin
            if (load) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
      out_valid_in = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vok_ff <= vram_rok;
      idx_ff <= idx_in;
      if (pop) cur_ff <= q_entry;
      if (emit) out_row_ff <= row;
      case (state_ff)
         ST_TCODE:  col_ff   <= col_diff[6:0];
         ST_TATTR:  code_ff  <= vbyte;
         ST_TPAL0:  attr_ff  <= vbyte;
         ST_TPAL1:  fg_gb_ff <= pal_rd;
         ST_TPAL2:  fg_r_ff  <= pal_rd;
         ST_TPAL3:  bg_gb_ff <= pal_rd;
         ST_TFONT0: bg_r_ff  <= pal_rd;
         ST_GREM:   gx_ff    <= gdiff[8:0];
         ST_GPAL0:  pix_ff   <= vbyte;
         ST_GPAL1:  fg_gb_ff <= pal_rd;
         default: ;
      endcase
   end

   assign out_valid = out_valid_ff;
   assign out_row   = out_row_ff;

   vbr_ram #(.WIDTH(8), .DEPTH(VIDEO_MEMORY_BYTES)) u_vram (
      .clock   (clock),
      .wr_en   (vram_we),
      .wr_addr (vram_wa),
      .wr_data (wdata),
      .rd_addr (vram_ra16[VAW-1:0]),
      .rd_data (vram_rd)
   );

   vbr_ram #(.WIDTH(8), .DEPTH(vbr_pkg::FONT_BYTES)) u_font (
      .clock   (clock),
      .wr_en   (font_we),
      .wr_addr (font_wa),
      .wr_data (wdata),
      .rd_addr (font_ra),
      .rd_data (font_rd)
   );

   vbr_ram #(.WIDTH(8), .DEPTH(vbr_pkg::PAL_BYTES)) u_pal (
      .clock   (clock),
      .wr_en   (pal_we),
      .wr_addr (pal_wa),
      .wr_data (wdata),
      .rd_addr (pal_ra),
      .rd_data (pal_rd)
   );

endmodule
